[rtl/grid_interpolated_texture_mapper_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grid texture mapper
// Concurrent assertion wrappers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef GRID_INTERPOLATED_TEXTURE_MAPPER_ASSERT_SVH
`define GRID_INTERPOLATED_TEXTURE_MAPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define GITM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gitm assertion failed");

// cond must never be true outside reset
`define GITM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gitm forbidden condition seen");

`else

`define GITM_ASSERT(lbl, clk, rst_n, prop)
`define GITM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/gitm_pkg.sv]
// ----------------------------------------------------------------------------
// gitm_pkg
// Constants, field layout and types of the grid texture mapper.
// ----------------------------------------------------------------------------
package gitm_pkg;

  localparam int CELLS_ACROSS = 40;
  localparam int CELLS_DOWN   = 25;
  localparam int CELL_SHIFT   = 3;
  localparam int CELL         = 1 << CELL_SHIFT;

  localparam int GRID_W  = CELLS_ACROSS + 1;
  localparam int GRID_H  = CELLS_DOWN + 1;
  localparam int GRID_N  = GRID_W * GRID_H;
  localparam int GRID_AW = $clog2(GRID_N);

  // field widths
  localparam int OP_W    = 2;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int VAL_W   = 32;
  localparam int TADDR_W = 16;
  localparam int BYTE_W  = 8;
  localparam int XY_W    = CELL_SHIFT;

  // u, v, light
  localparam int COMP_N = 3;
  localparam int COMP_W = 2;
  localparam int GRID_DW = COMP_N * VAL_W;
  localparam int CORNER_N = 4;
  localparam int SEQ_W = 3;

  // input word layout
  localparam int COL_LSB   = 0;
  localparam int ROW_LSB   = COL_LSB + COL_W;
  localparam int U_LSB     = ROW_LSB + ROW_W;
  localparam int V_LSB     = U_LSB + VAL_W;
  localparam int L_LSB     = V_LSB + VAL_W;
  localparam int TADDR_LSB = L_LSB + VAL_W;
  localparam int TDATA_LSB = TADDR_LSB + TADDR_W;
  localparam int S_USED_W  = TDATA_LSB + BYTE_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  // output word layout
  localparam int M_USED_W  = BYTE_W + 2 * XY_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

  typedef enum logic [OP_W-1:0] {
    OP_GRID_WR  = 2'd0,
    OP_TEX_WR   = 2'd1,
    OP_SHADE_WR = 2'd2,
    OP_RENDER   = 2'd3
  } gitm_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EDGE,
    ST_ROW,
    ST_PIXEL,
    ST_ADV,
    ST_DRAIN
  } gitm_state_e;

endpackage

[rtl/grid_interpolated_texture_mapper.sv]
// ----------------------------------------------------------------------------
// grid_interpolated_texture_mapper
// Bilinear u/v/light stepping over one grid cell, texture then shade lookup.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                    contents
//  s_axis   in   s_axis_tvalid_i/tready_o     tuser: operation; tdata: point,
//                                             table write or cell to render
//  m_axis   out  m_axis_tvalid_o/tready_i     tdata: pixel, x, y; tlast: last
//
// A render runs the corner grid reads, an edge step per component and side,
// then per row a row step per component, a pixel per cell column and an
// edge update per component and side (none after the last row); the steps
// share one subtract-shift/add unit, the pixels have their own adders and
// go out at one a cycle while m_axis is not stalled. Stalls on m_axis freeze
// the pixel pipeline. Reset clears control only; stores hold garbage until written.
`include "grid_interpolated_texture_mapper_assert.svh"

module grid_interpolated_texture_mapper
  import gitm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // column, row, u_value, v_value, light_value, table_address, table_data
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // operation
  input  logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // pixel, pixel_x, pixel_y
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  // input fields
  gitm_op_e           op;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [GRID_DW-1:0] pt_word;
  logic [TADDR_W-1:0] taddr;
  logic [BYTE_W-1:0]  tbyte;
  logic               in_acc;
  logic [GRID_AW-1:0] in_addr;

  assign op      = gitm_op_e'(s_axis_tuser_i);
  assign col     = s_axis_tdata_i[COL_LSB +: COL_W];
  assign row     = s_axis_tdata_i[ROW_LSB +: ROW_W];
  assign pt_word = {s_axis_tdata_i[L_LSB +: VAL_W], s_axis_tdata_i[V_LSB +: VAL_W],
                    s_axis_tdata_i[U_LSB +: VAL_W]};
  assign taddr   = s_axis_tdata_i[TADDR_LSB +: TADDR_W];
  assign tbyte   = s_axis_tdata_i[TDATA_LSB +: BYTE_W];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_addr = GRID_AW'(row) * GRID_AW'(GRID_W) + GRID_AW'(col);

  // control state
  gitm_state_e        state_q, state_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [XY_W-1:0]    px_q, px_d, py_q, py_d;
  logic [GRID_AW-1:0] base_q, base_d;
  logic               issue, adv;
  logic               grid_we, tex_we, shade_we;

  // datapath
  logic [VAL_W-1:0] left_q  [COMP_N];
  logic [VAL_W-1:0] right_q [COMP_N];
  logic [VAL_W-1:0] botl_q  [COMP_N];
  logic [VAL_W-1:0] botr_q  [COMP_N];
  logic [VAL_W-1:0] lstep_q [COMP_N];
  logic [VAL_W-1:0] rstep_q [COMP_N];
  logic [VAL_W-1:0] xstep_q [COMP_N];
  logic [VAL_W-1:0] acc_q   [COMP_N];

  logic               side;
  logic [COMP_W-1:0]  comp;
  logic [VAL_W-1:0]   alu_a, alu_b, alu_diff, alu_sum, alu_res;
  logic               alu_sub;

  // stores
  logic [GRID_DW-1:0] grid_mem [GRID_N];
  logic [BYTE_W-1:0]  tex_mem  [2**TADDR_W];
  logic [BYTE_W-1:0]  shade_mem[2**TADDR_W];
  logic [GRID_DW-1:0] grid_rd_q;
  logic [GRID_AW-1:0] grid_raddr;
  logic [TADDR_W-1:0] tex_idx;
  logic [BYTE_W-1:0]  tex_rd_q, shade_rd_q;

  // pixel pipeline
  logic               s1_valid_q, out_valid_q;
  logic [XY_W-1:0]    s1_x_q, s1_y_q, out_x_q, out_y_q;
  logic               s1_last_q, out_last_q;
  logic [BYTE_W-1:0]  s1_light_q;

  assign adv = !out_valid_q || m_axis_tready_i;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seq_q   <= '0;
      px_q    <= '0;
      py_q    <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      px_q    <= px_d;
      py_q    <= py_d;
      base_q  <= base_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    seq_d    = seq_q;
    px_d     = px_q;
    py_d     = py_q;
    base_d   = base_q;
    issue    = 1'b0;
    grid_we  = 1'b0;
    tex_we   = 1'b0;
    shade_we = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_GRID_WR:  grid_we  = (col <= COL_W'(CELLS_ACROSS)) &&
                                    (row <= ROW_W'(CELLS_DOWN));
            OP_TEX_WR:   tex_we   = 1'b1;
            OP_SHADE_WR: shade_we = 1'b1;
            OP_RENDER: begin
              if ((col < COL_W'(CELLS_ACROSS)) && (row < ROW_W'(CELLS_DOWN))) begin
                base_d  = in_addr;
                seq_d   = '0;
                py_d    = '0;
                state_d = ST_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        // four reads, the last captured in the cycle after the last read
        if (seq_q == SEQ_W'(CORNER_N)) begin
          seq_d   = '0;
          state_d = ST_EDGE;
        end else begin
          seq_d = seq_q + 1'b1;
        end
      end
      ST_EDGE: begin
        if (seq_q == SEQ_W'(2 * COMP_N - 1)) begin
          seq_d   = '0;
          state_d = ST_ROW;
        end else begin
          seq_d = seq_q + 1'b1;
        end
      end
      ST_ROW: begin
        if (seq_q == SEQ_W'(COMP_N - 1)) begin
          seq_d   = '0;
          px_d    = '0;
          state_d = ST_PIXEL;
        end else begin
          seq_d = seq_q + 1'b1;
        end
      end
      ST_PIXEL: begin
        if (adv) begin
          issue = 1'b1;
          px_d  = px_q + 1'b1;
          if (px_q == XY_W'(CELL - 1)) begin
            state_d = (py_q == XY_W'(CELL - 1)) ? ST_DRAIN : ST_ADV;
          end
        end
      end
      ST_ADV: begin
        if (seq_q == SEQ_W'(2 * COMP_N - 1)) begin
          seq_d   = '0;
          py_d    = py_q + 1'b1;
          state_d = ST_ROW;
        end else begin
          seq_d = seq_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // table writes must not overtake a pending shade read
        if (!s1_valid_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // ---------------- shared step unit ----------------
  always_comb begin
    side = (seq_q >= SEQ_W'(COMP_N));
    comp = side ? COMP_W'(seq_q - SEQ_W'(COMP_N)) : COMP_W'(seq_q);
    alu_a   = left_q[comp];
    alu_b   = right_q[comp];
    alu_sub = 1'b1;
    case (state_q)
      ST_EDGE: begin
        alu_a = side ? botr_q[comp] : botl_q[comp];
        alu_b = side ? right_q[comp] : left_q[comp];
      end
      ST_ROW: begin
        alu_a = right_q[comp];
        alu_b = left_q[comp];
      end
      ST_ADV: begin
        alu_a   = side ? right_q[comp] : left_q[comp];
        alu_b   = side ? rstep_q[comp] : lstep_q[comp];
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  assign alu_diff = alu_a - alu_b;
  assign alu_sum  = alu_a + alu_b;
  assign alu_res  = alu_sub ? $unsigned($signed(alu_diff) >>> CELL_SHIFT) : alu_sum;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        for (int k = 0; k < COMP_N; k++) begin
          case (seq_q)
            3'd1:    left_q[k]  <= grid_rd_q[k*VAL_W +: VAL_W];
            3'd2:    right_q[k] <= grid_rd_q[k*VAL_W +: VAL_W];
            3'd3:    botl_q[k]  <= grid_rd_q[k*VAL_W +: VAL_W];
            3'd4:    botr_q[k]  <= grid_rd_q[k*VAL_W +: VAL_W];
            default: ;
          endcase
        end
      end
      ST_EDGE: begin
        if (side) rstep_q[comp] <= alu_res;
        else      lstep_q[comp] <= alu_res;
      end
      ST_ROW: begin
        xstep_q[comp] <= alu_res;
        acc_q[comp]   <= left_q[comp];
      end
      ST_PIXEL: begin
        if (issue) begin
          for (int k = 0; k < COMP_N; k++) acc_q[k] <= acc_q[k] + xstep_q[k];
        end
      end
      ST_ADV: begin
        if (side) right_q[comp] <= alu_res;
        else      left_q[comp]  <= alu_res;
      end
      default: ;
    endcase
  end

  // ---------------- stores ----------------
  always_comb begin
    case (seq_q)
      3'd0:    grid_raddr = base_q;
      3'd1:    grid_raddr = base_q + 1'b1;
      3'd2:    grid_raddr = base_q + GRID_AW'(GRID_W);
      default: grid_raddr = base_q + GRID_AW'(GRID_W + 1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[in_addr] <= pt_word;
    grid_rd_q <= grid_mem[grid_raddr];
  end

  // texel: bits 15:8 of u low, bits 15:8 of v high
  assign tex_idx = {acc_q[1][15:8], acc_q[0][15:8]};

  always_ff @(posedge clk_i) begin
    if (tex_we) tex_mem[taddr] <= tbyte;
    if (adv)    tex_rd_q <= tex_mem[tex_idx];
  end

  always_ff @(posedge clk_i) begin
    if (shade_we) shade_mem[taddr] <= tbyte;
    if (adv)      shade_rd_q <= shade_mem[{s1_light_q, tex_rd_q}];
  end

  // ---------------- pixel pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q     <= px_q;
      s1_y_q     <= py_q;
      s1_last_q  <= (px_q == XY_W'(CELL - 1)) && (py_q == XY_W'(CELL - 1));
      s1_light_q <= acc_q[2][15:8];
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, out_y_q, out_x_q, shade_rd_q};
  assign m_axis_tlast_o  = out_last_q;

  // ---------------- assertions ----------------
  `GITM_ASSERT(a_last_corner, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tlast_o) |-> ((out_x_q == XY_W'(CELL - 1)) && (out_y_q == XY_W'(CELL - 1))))
  `GITM_ASSERT_NEVER(a_ready_with_lookup, clk_i, rst_ni, s_axis_tready_o && s1_valid_q)
  `GITM_ASSERT(a_issue_moves, clk_i, rst_ni, issue |=> s1_valid_q)

endmodule
